FILE: rtl/rvsf_pkg.sv
package rvsf_pkg;

  localparam int ENTRIES = 2048;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int WORD_W  = 9;
  localparam int COUNT_W = 12;
  localparam int CFG_W   = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_COMPARE_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_VALUE = 1'd1;

  localparam logic CMD_CAPTURE = 1'b0;
  localparam logic CMD_FILTER  = 1'b1;

  typedef enum logic [2:0] {
    CMP_LOWER     = 3'd0,
    CMP_HIGHER    = 3'd1,
    CMP_IDENTICAL = 3'd2,
    CMP_DIFFERENT = 3'd3,
    CMP_TARGET    = 3'd4
  } cmp_mode_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic        cmd;
    logic [10:0] address;
    logic [7:0]  current_byte;
    logic        pass_end;
  } in_item_t;

  typedef struct packed {
    logic               survives;
    logic [7:0]         previous_byte;
    logic [COUNT_W-1:0] pass_count;
    logic               last_of_pass;
  } out_item_t;

  typedef struct packed {
    logic clear_en;
    logic accept;
    logic exec;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_status_t;

endpackage

FILE: rtl/rvsf_ctrl.sv
module rvsf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  rvsf_pkg::dp_status_t status,
  output rvsf_pkg::dp_cmd_t    cmd
);
  import rvsf_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd           = '0;
    in_stall      = 1'b1;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (status.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!out_valid_r || !out_stall) begin
          cmd.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/rvsf_dp.sv
module rvsf_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rvsf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rvsf_pkg::CFG_W-1:0]        cfg_wdata,
  input  rvsf_pkg::in_item_t                in_data,
  output rvsf_pkg::out_item_t               out_data,
  input  rvsf_pkg::dp_cmd_t                 cmd,
  output rvsf_pkg::dp_status_t              status
);
  import rvsf_pkg::*;

  logic [WORD_W-1:0] mem [ENTRIES];

  cmp_mode_t          mode_r;
  logic [7:0]         target_r;
  logic [ADDR_W-1:0]  clear_cnt_r;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               fresh_r;
  in_item_t           item_r;
  logic [WORD_W-1:0]  rd_q_r;
  out_item_t          out_r;

  logic [ADDR_W-1:0]  rd_idx;
  logic [ADDR_W-1:0]  item_idx;
  logic [ADDR_W-1:0]  wr_idx;
  logic [WORD_W-1:0]  wr_word;
  logic               wr_en;
  logic [7:0]         old_byte;
  logic               old_mark;
  logic               hit;
  logic               keep;
  logic [COUNT_W-1:0] count_base;

  assign rd_idx   = ADDR_W'(in_data.address);
  assign item_idx = ADDR_W'(item_r.address);
  assign old_byte = rd_q_r[7:0];
  assign old_mark = rd_q_r[8];

  always_comb begin
    case (mode_r)
      CMP_LOWER:     hit = item_r.current_byte <  old_byte;
      CMP_HIGHER:    hit = item_r.current_byte >  old_byte;
      CMP_IDENTICAL: hit = item_r.current_byte == old_byte;
      CMP_DIFFERENT: hit = item_r.current_byte != old_byte;
      CMP_TARGET:    hit = item_r.current_byte == target_r;
      default:       hit = 1'b0;
    endcase
  end

  always_comb begin
    keep       = (item_r.cmd == CMD_CAPTURE) ? 1'b1 : (old_mark & hit);
    count_base = fresh_r ? '0 : count_r;
    count_nxt  = (keep && count_base != COUNT_MAX) ? count_base + 1'b1 : count_base;
  end

  always_comb begin
    wr_en   = cmd.clear_en | cmd.exec;
    wr_idx  = cmd.clear_en ? clear_cnt_r : item_idx;
    wr_word = cmd.clear_en ? '0 : {keep, keep ? item_r.current_byte : old_byte};
  end

  assign status.clear_last = (clear_cnt_r == ADDR_W'(ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_word;
    if (cmd.accept) rd_q_r <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= CMP_IDENTICAL;
      target_r    <= '0;
      clear_cnt_r <= '0;
      count_r     <= '0;
      fresh_r     <= 1'b1;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_COMPARE_MODE: mode_r   <= cmp_mode_t'(cfg_wdata[2:0]);
          REG_TARGET_VALUE: target_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.clear_en) clear_cnt_r <= clear_cnt_r + 1'b1;
      if (cmd.exec) begin
        count_r <= count_nxt;
        fresh_r <= item_r.pass_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) item_r <= in_data;
    if (cmd.exec) begin
      out_r.survives      <= keep;
      out_r.previous_byte <= old_byte;
      out_r.pass_count    <= count_nxt;
      out_r.last_of_pass  <= item_r.pass_end;
    end
  end

  assign out_data = out_r;

endmodule

FILE: rtl/ram_value_search_filter_core.sv
// The input beat and its memory read are registered, then the result register is loaded;
// the load waits while the result register stalls. A new item is taken only after the current
// one has been read from and written back to the shared byte/mark memory (one port access each).
// Reset: synchronous, active low; then a clearing pass over all 2048 entries (one entry per
// cycle) wipes the candidate marks while in_stall stays high; config writes still land.
module ram_value_search_filter_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rvsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rvsf_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rvsf_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output rvsf_pkg::out_item_t            out_data
);
  import rvsf_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  rvsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  rvsf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

FILE: rtl/rvsf_checker.sv
module rvsf_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           cfg_we,
  input logic [rvsf_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [rvsf_pkg::CFG_W-1:0]     cfg_wdata,
  input logic                           in_valid,
  input logic                           in_stall,
  input rvsf_pkg::in_item_t             in_data,
  input logic                           out_valid,
  input logic                           out_stall,
  input rvsf_pkg::out_item_t            out_data
);
  import rvsf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result payload changed");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat taken while an item is in work");

  a_stall_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input ready during the clearing pass");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in work");

endmodule

bind ram_value_search_filter_core rvsf_checker u_rvsf_checker (.*);
